### design/pspd_pkg.sv
// shared types and constants for the speed pid duty controller
`default_nettype none

package pspd_pkg;

    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 8;
    localparam int CEIL_W  = 7;
    localparam int ERR_W   = VEL_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int ACC_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 3;
    localparam int CDATA_W = 16;

    localparam int PROP_W  = ERR_W + GAIN_W + 1;
    localparam int DERV_W  = DIFF_W + GAIN_W + 1;
    localparam int INTP_W  = ACC_W + GAIN_W + 1;
    localparam int INTQ_W  = INTP_W - FRAC_W;
    localparam int PD_W    = DERV_W + 1;
    localparam int TOT_W   = PD_W + 1;
    localparam int QUO_W   = TOT_W - FRAC_W;

    typedef enum logic [IDX_W-1:0] {
        CFG_GAIN_PROP    = 3'd0,
        CFG_GAIN_INTEG   = 3'd1,
        CFG_GAIN_DERIV   = 3'd2,
        CFG_DUTY_FLOOR   = 3'd3,
        CFG_DUTY_CEILING = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0] gain_prop;
        logic        [GAIN_W-1:0] gain_integ;
        logic        [GAIN_W-1:0] gain_deriv;
        logic signed [DUTY_W-1:0] duty_floor;
        logic        [CEIL_W-1:0] duty_ceiling;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [ACC_W-1:0]  acc;
    } t_err_stage;

    typedef struct packed {
        logic signed [PROP_W-1:0] prop;
        logic signed [DERV_W-1:0] deriv;
        logic signed [INTP_W-1:0] integ;
    } t_prod_stage;

endpackage

`default_nettype wire

### design/pid_speed_to_duty_core.sv
// top level of the speed pid controller producing a duty percent
//
// One request carries a target and a measured velocity (signed Q8.8) and yields one
// signed integer duty percent. A request can be taken every clock cycle while the output
// is not stalled; each result passes five registers on its way to the output: error and
// saturating sum, the three gain multiplies, integral clamp with partial sum, full sum,
// then truncation and the duty clamp into the output register.
// Every stage stalls on its own, so the input keeps taking requests until the whole
// pipeline is full behind a stalled output. When the floor is set above the ceiling, a
// value above the ceiling gives the ceiling and any other value gives the floor.
// Configuration writes are taken every cycle and must only happen while no request is
// in flight.
`default_nettype none

module pid_speed_to_duty_core
    import pspd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [15:0] target_velocity, [31:16] measured_velocity
    input  wire logic [2*VEL_W-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] duty_percent
    output logic [DUTY_W-1:0]       m_axis_tdata,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data
);

    t_cfg        cfg;
    logic        err_valid;
    logic        err_ready;
    t_err_stage  err_data;
    logic        mul_valid;
    logic        mul_ready;
    t_prod_stage mul_data;

    pspd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pspd_err u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_target   ($signed(s_axis_tdata[VEL_W-1:0])),
        .i_measured ($signed(s_axis_tdata[2*VEL_W-1:VEL_W])),
        .o_valid    (err_valid),
        .o_data     (err_data),
        .i_ready    (err_ready)
    );

    pspd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (err_valid),
        .o_ready (err_ready),
        .i_data  (err_data),
        .i_cfg   (cfg),
        .o_valid (mul_valid),
        .o_data  (mul_data),
        .i_ready (mul_ready)
    );

    pspd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_data  (mul_data),
        .i_cfg   (cfg),
        .o_valid (m_axis_tvalid),
        .o_duty  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

    a_duty_ceiling : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata) <= $signed({1'b0, cfg.duty_ceiling}))
            || ($signed(m_axis_tdata) == cfg.duty_floor)))
        else $error("duty above ceiling");

    a_duty_floor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (cfg.duty_floor <= $signed({1'b0, cfg.duty_ceiling})))
            |-> ($signed(m_axis_tdata) >= cfg.duty_floor))
        else $error("duty below floor");

endmodule

`default_nettype wire

### design/pspd_cfg.sv
// configuration register file for gains and duty limits
`default_nettype none

module pspd_cfg
    import pspd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:    n_cfg.gain_prop    = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:   n_cfg.gain_integ   = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:   n_cfg.gain_deriv   = i_cfg_data[GAIN_W-1:0];
                CFG_DUTY_FLOOR:   n_cfg.duty_floor   = $signed(i_cfg_data[DUTY_W-1:0]);
                CFG_DUTY_CEILING: n_cfg.duty_ceiling = i_cfg_data[CEIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### design/pspd_err.sv
// error, difference and saturating error sum stage
`default_nettype none

module pspd_err
    import pspd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [VEL_W-1:0] i_target,
    input  wire logic signed [VEL_W-1:0] i_measured,
    output logic                         o_valid,
    output t_err_stage                   o_data,
    input  wire logic                    i_ready
);

    logic                    r_valid;
    t_err_stage              r_data;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ERR_W-1:0] r_prev;

    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        err  = ERR_W'(i_target) - ERR_W'(i_measured);
        diff = DIFF_W'(r_prev) - DIFF_W'(err);
        sum  = (ACC_W+1)'(r_acc) + (ACC_W+1)'(err);
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            n_acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_prev  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_acc  <= n_acc;
                r_prev <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.err  <= err;
            r_data.diff <= diff;
            r_data.acc  <= n_acc;
        end
    end

    a_accept_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_valid && r_data.acc == r_acc))
        else $error("accepted request did not load the error stage");

endmodule

`default_nettype wire

### design/pspd_mul.sv
// gain multiply stage
`default_nettype none

module pspd_mul
    import pspd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_err_stage i_data,
    input  wire t_cfg       i_cfg,
    output logic            o_valid,
    output t_prod_stage     o_data,
    input  wire logic       i_ready
);

    logic        r_valid;
    t_prod_stage r_data;
    t_prod_stage n_data;

    logic signed [GAIN_W:0] gp;
    logic signed [GAIN_W:0] gi;
    logic signed [GAIN_W:0] gd;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        gp = $signed({1'b0, i_cfg.gain_prop});
        gi = $signed({1'b0, i_cfg.gain_integ});
        gd = $signed({1'b0, i_cfg.gain_deriv});
        n_data.prop  = PROP_W'(i_data.err) * PROP_W'(gp);
        n_data.deriv = DERV_W'(i_data.diff) * DERV_W'(gd);
        n_data.integ = INTP_W'(i_data.acc) * INTP_W'(gi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### design/pspd_out.sv
// integral clamp, term sum, truncation and duty clamp stages
`default_nettype none

module pspd_out
    import pspd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_prod_stage i_data,
    input  wire t_cfg        i_cfg,
    output logic             o_valid,
    output logic [DUTY_W-1:0] o_duty,
    input  wire logic        i_ready
);

    logic                     r_v1;
    logic signed [DUTY_W-1:0] r_integ;
    logic signed [PD_W-1:0]   r_pd;
    logic                     r_v2;
    logic signed [TOT_W-1:0]  r_total;
    logic                     r_v3;
    logic signed [DUTY_W-1:0] r_duty;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic signed [INTQ_W-1:0] iq;
    logic signed [DUTY_W-1:0] ceil_s;
    logic signed [DUTY_W-1:0] n_integ;
    logic signed [PD_W-1:0]   n_pd;
    logic signed [TOT_W-1:0]  n_total;
    logic signed [QUO_W-1:0]  q;
    logic signed [DUTY_W-1:0] n_duty;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_duty  = r_duty;

    always_comb begin
        ceil_s = $signed({1'b0, i_cfg.duty_ceiling});
        iq = i_data.integ[INTP_W-1:FRAC_W]
           + INTQ_W'(i_data.integ[INTP_W-1] && (i_data.integ[FRAC_W-1:0] != '0));
        if (iq > INTQ_W'(ceil_s)) begin
            n_integ = ceil_s;
        end else if (iq < INTQ_W'(-ceil_s)) begin
            n_integ = -ceil_s;
        end else begin
            n_integ = iq[DUTY_W-1:0];
        end
        n_pd = PD_W'(i_data.prop) + PD_W'(i_data.deriv);
    end

    always_comb begin
        n_total = TOT_W'(r_pd) + {(QUO_W)'(r_integ), {FRAC_W{1'b0}}};
    end

    always_comb begin
        q = r_total[TOT_W-1:FRAC_W]
          + QUO_W'(r_total[TOT_W-1] && (r_total[FRAC_W-1:0] != '0));
        priority if (q > QUO_W'(ceil_s)) begin
            n_duty = ceil_s;
        end else if (q < QUO_W'(i_cfg.duty_floor)) begin
            n_duty = i_cfg.duty_floor;
        end else begin
            n_duty = q[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r_integ <= n_integ;
            r_pd    <= n_pd;
        end
        if (r_v1 && rdy2) begin
            r_total <= n_total;
        end
        if (r_v2 && rdy3) begin
            r_duty <= n_duty;
        end
    end

    a_integ_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_integ <= ceil_s && r_integ >= -ceil_s))
        else $error("integral term outside ceiling bound");

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for pid_speed_to_duty_core: velocity requests checked against a duty predictor
`timescale 1ns / 1ps

module tb;
    import pspd_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int PIPE_DEPTH  = 5;
    localparam int QUIET_LIMIT = 4000;
    localparam int N_RANDOM    = 250;
    localparam int N_WINDUP_UP = 120;
    localparam int N_WINDUP_DN = 70;
    localparam int MAX_REPORTS = 20;
    localparam int CFG_SPARE_FIRST = 5;
    localparam longint FRAC_ONE = 64'sd65536;
    localparam longint ACC_MAX  = 64'sd2147483647;
    localparam longint ACC_MIN  = -64'sd2147483648;

    typedef struct {
        bit                 drain;
        logic [2*VEL_W-1:0] vel;
    } t_vel_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*VEL_W-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DUTY_W-1:0]    m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CDATA_W-1:0]   i_cfg_data = '0;

    t_vel_req              vel_reqs[$];
    t_vel_req              next_req;
    logic [DUTY_W-1:0]     duty_exp[$];
    t_cfg                  pid_cfg = '0;
    longint                err_sum = 0;
    longint                last_err = 0;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    int                    n_req = 0;
    int                    n_duty = 0;
    int                    n_cfg = 0;
    int                    mismatches = 0;
    int                    quiet = 0;

    pid_speed_to_duty_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [DUTY_W-1:0] duty_step(input logic [2*VEL_W-1:0] req);
        longint tgt, meas, e, d, sum, integ, total, duty, ceil_v, floor_v;
        tgt     = $signed(req[VEL_W-1:0]);
        meas    = $signed(req[2*VEL_W-1:VEL_W]);
        ceil_v  = longint'(pid_cfg.duty_ceiling);
        floor_v = $signed(pid_cfg.duty_floor);
        e = tgt - meas;
        d = last_err - e;
        sum = err_sum + e;
        if (sum > ACC_MAX) begin
            sum = ACC_MAX;
        end else if (sum < ACC_MIN) begin
            sum = ACC_MIN;
        end
        err_sum  = sum;
        last_err = e;
        integ = (err_sum * longint'(pid_cfg.gain_integ)) / FRAC_ONE;
        if (integ > ceil_v) begin
            integ = ceil_v;
        end else if (integ < -ceil_v) begin
            integ = -ceil_v;
        end
        total = e * longint'(pid_cfg.gain_prop) + integ * FRAC_ONE
              + d * longint'(pid_cfg.gain_deriv);
        duty = total / FRAC_ONE;
        if (duty > ceil_v) begin
            duty = ceil_v;
        end else if (duty < floor_v) begin
            duty = floor_v;
        end
        return duty[DUTY_W-1:0];
    endfunction

    task automatic push_vel(input int tgt, input int meas, input bit drain);
        t_vel_req r;
        r.drain = drain;
        r.vel   = {meas[VEL_W-1:0], tgt[VEL_W-1:0]};
        vel_reqs.push_back(r);
    endtask

    task automatic add_random(input int n);
        int kind, tgt, meas;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                tgt  = int'($urandom_range(40000)) - 20000;
                meas = tgt + int'($urandom_range(16000)) - 8000;
            end else if (kind < 85) begin
                tgt  = $urandom;
                meas = $urandom;
            end else begin
                tgt  = ($urandom_range(1)) ? 32767 : -32768;
                meas = int'($urandom_range(2)) - 1;
                if ($urandom_range(1)) begin
                    meas = ($urandom_range(1)) ? 32767 : -32768;
                end
            end
            push_vel(tgt, meas, (i % 97) == 96);
        end
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_GAIN_PROP:    pid_cfg.gain_prop    = data;
            CFG_GAIN_INTEG:   pid_cfg.gain_integ   = data;
            CFG_GAIN_DERIV:   pid_cfg.gain_deriv   = data;
            CFG_DUTY_FLOOR:   pid_cfg.duty_floor   = data[DUTY_W-1:0];
            CFG_DUTY_CEILING: pid_cfg.duty_ceiling = data[CEIL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input int gp, input int gi, input int gd,
                                input int fl, input int ce);
        logic [CDATA_W-1:0] junk;
        junk = CDATA_W'($urandom);
        cfg_write(CFG_GAIN_PROP, gp[CDATA_W-1:0]);
        cfg_write(CFG_GAIN_INTEG, gi[CDATA_W-1:0]);
        cfg_write(CFG_GAIN_DERIV, gd[CDATA_W-1:0]);
        // upper bits carry junk that must be dropped
        cfg_write(CFG_DUTY_FLOOR, {junk[CDATA_W-1:DUTY_W], fl[DUTY_W-1:0]});
        cfg_write(CFG_DUTY_CEILING, {junk[CDATA_W-1:CEIL_W], ce[CEIL_W-1:0]});
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (vel_reqs.size() != 0 || s_axis_tvalid || duty_exp.size() != 0);
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                duty_exp.push_back(duty_step(s_axis_tdata));
                n_req++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (vel_reqs.size() != 0 && !(vel_reqs[0].drain && duty_exp.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    next_req = vel_reqs.pop_front();
                    s_axis_tdata  <= next_req.vel;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // duty monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_duty++;
                if (duty_exp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t unexpected duty result %0d", $time,
                                 $signed(m_axis_tdata));
                    end
                end else if (m_axis_tdata !== duty_exp[0]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t duty mismatch: expected %0d, got %0d", $time,
                                 $signed(duty_exp[0]), $signed(m_axis_tdata));
                    end
                    void'(duty_exp.pop_front());
                end else begin
                    void'(duty_exp.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, quiet);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all gains zero after reset
        push_vel(32767, -32768, 1'b0);
        push_vel(-32768, 32767, 1'b0);
        push_vel(1234, -77, 1'b0);
        wait_drained();

        for (int k = CFG_SPARE_FIRST; k < 2 ** IDX_W; k++) begin
            cfg_write(k[IDX_W-1:0], CDATA_W'($urandom));
        end

        load_setting(256, 8, 128, -100, 100);
        push_vel(32767, -32768, 1'b0);
        push_vel(-32768, 32767, 1'b0);
        push_vel(0, 0, 1'b0);
        push_vel(32767, 32767, 1'b0);
        push_vel(-32768, -32768, 1'b0);
        push_vel(1, 0, 1'b0);
        push_vel(0, 1, 1'b0);
        push_vel(-1, 0, 1'b0);
        push_vel(256, 0, 1'b0);
        push_vel(0, 256, 1'b0);
        push_vel(25600, 0, 1'b0);
        push_vel(-25600, 0, 1'b0);
        push_vel(25855, 0, 1'b0);
        push_vel(0, 25855, 1'b0);
        push_vel(-32768, 0, 1'b0);
        push_vel(0, -32768, 1'b0);
        push_vel(100, 99, 1'b0);
        add_random(N_RANDOM);
        wait_drained();

        send_idle_pct = 70;
        stall_pct     = 0;
        load_setting(65535, 65535, 65535, -128, 127);
        add_random(N_RANDOM);
        wait_drained();

        // floor above ceiling
        send_idle_pct = 0;
        stall_pct     = 70;
        load_setting($urandom_range(1024), $urandom_range(64), $urandom_range(2048), 50, 20);
        add_random(N_RANDOM);
        wait_drained();

        send_idle_pct = 7;
        stall_pct     = 7;
        load_setting(512, 3, 1024, 127, 90);
        add_random(N_RANDOM);
        wait_drained();

        // push the error sum hard one way and then back the other way
        send_idle_pct = 0;
        stall_pct     = 0;
        load_setting(64, 1, 32, -50, 100);
        for (int i = 0; i < N_WINDUP_UP; i++) begin
            push_vel(32000 + int'($urandom_range(767)), -32000 - int'($urandom_range(768)),
                     1'b0);
        end
        for (int i = 0; i < N_WINDUP_DN; i++) begin
            push_vel(-32000 - int'($urandom_range(768)), 32000 + int'($urandom_range(767)),
                     1'b0);
        end
        add_random(40);
        wait_drained();

        $display("covered %0d velocity requests and %0d duty results over %0d register writes",
                 n_req, n_duty, n_cfg);
        $display("settings spanned zero and full gains, inverted limits and large error sums");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
